FILE: rtl/gipq_pkg.sv
`default_nettype none
package gipq_pkg;

    // default sizes
    localparam int TILE_SIZE_DEF   = 64;
    localparam int TILE_REPEAT_DEF = 5;
    localparam int QUEUE_DEPTH_DEF = 1024;

    // fixed field widths
    localparam int COORD_W = 9;
    localparam int DIST_W  = 16;
    localparam int COST_W  = 4;
    localparam int STEP_W  = 4;
    localparam int ENTRY_W = 2 * COORD_W + DIST_W;

    // item modes
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_RELAX = 2'd1;
    localparam logic [1:0] MODE_POP   = 2'd2;

    // result status codes
    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_DECREASE = 3'd2;
    localparam logic [2:0] ST_NOT_IMPR = 3'd3;
    localparam logic [2:0] ST_RANGE    = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;
    localparam logic [2:0] ST_EMPTY    = 3'd6;

    // queue read address select
    localparam logic [1:0] QR_DEC = 2'd0;
    localparam logic [1:0] QR_CUR = 2'd1;
    localparam logic [1:0] QR_INC = 2'd2;

    // result distance select
    localparam logic [1:0] RD_ZERO = 2'd0;
    localparam logic [1:0] RD_CAND = 2'd1;
    localparam logic [1:0] RD_TENT = 2'd2;

    typedef struct packed {
        logic       latch_in;
        logic       div_step;
        logic       tile_wr;
        logic       tile_rd;
        logic       cell_rd;
        logic       t_load;
        logic       wrap_step;
        logic       cand_load;
        logic       flag_wr;
        logic       flag_val;
        logic       flag_clr;
        logic       tent_wr;
        logic       q_rd;
        logic [1:0] q_rd_sel;
        logic       q_wr;
        logic       q_wr_new;
        logic       ptr_zero;
        logic       ptr_set_cnt;
        logic       ptr_set_cntm1;
        logic       ptr_inc;
        logic       ptr_dec;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       pop_latch;
        logic       res_load;
        logic [2:0] res_status;
        logic       res_rc;
        logic [1:0] res_dist;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       tile_ok;
        logic       grid_ok;
        logic       cnt_zero;
        logic       cnt_full;
        logic       div_busy;
        logic       steps_zero;
        logic       flag_set;
        logic       improved;
        logic       key_ge;
        logic       match;
        logic       ptr_zero;
        logic       ptr_at_cnt;
        logic       ptr_last;
        logic       clr_last;
        logic       out_free;
    } sts_t;

endpackage
`default_nettype wire

FILE: rtl/gipq_ram.sv
`default_nettype none
module gipq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                         clk,
    input  wire logic                                         wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                             wr_data,
    input  wire logic                                         rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/gipq_ctrl.sv
`default_nettype none
module gipq_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire gipq_pkg::sts_t  sts,
    output gipq_pkg::cmd_t       cmd
);

    localparam logic [4:0] S_CLEAR    = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_DECODE   = 5'd2;
    localparam logic [4:0] S_DIV      = 5'd3;
    localparam logic [4:0] S_TILE     = 5'd4;
    localparam logic [4:0] S_WRAP     = 5'd5;
    localparam logic [4:0] S_CHECK    = 5'd6;
    localparam logic [4:0] S_FIND_RD  = 5'd7;
    localparam logic [4:0] S_FIND_CMP = 5'd8;
    localparam logic [4:0] S_SH_RD    = 5'd9;
    localparam logic [4:0] S_SH_WR    = 5'd10;
    localparam logic [4:0] S_INS_RD   = 5'd11;
    localparam logic [4:0] S_INS_CMP  = 5'd12;
    localparam logic [4:0] S_POP0     = 5'd13;
    localparam logic [4:0] S_POP1     = 5'd14;
    localparam logic [4:0] S_OUT      = 5'd15;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic       is_dec_reg;
    logic       is_dec_next;
    logic [2:0] ins_status;

    assign s_tready   = (state_reg == S_IDLE);
    assign ins_status = is_dec_reg ? gipq_pkg::ST_DECREASE : gipq_pkg::ST_INSERTED;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            is_dec_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            is_dec_reg <= is_dec_next;
        end
    end

    // sequencer
    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        is_dec_next = is_dec_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.flag_clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.res_load = 1'b1;
                state_next   = S_OUT;
                case (sts.mode)
                    gipq_pkg::MODE_LOAD:
                    begin
                        if (sts.tile_ok)
                        begin
                            cmd.tile_wr    = 1'b1;
                            cmd.res_status = gipq_pkg::ST_DONE;
                            cmd.res_rc     = 1'b1;
                        end
                        else
                        begin
                            cmd.res_status = gipq_pkg::ST_RANGE;
                        end
                    end
                    gipq_pkg::MODE_RELAX:
                    begin
                        if (sts.grid_ok)
                        begin
                            cmd.res_load = 1'b0;
                            state_next   = S_DIV;
                        end
                        else
                        begin
                            cmd.res_status = gipq_pkg::ST_RANGE;
                        end
                    end
                    gipq_pkg::MODE_POP:
                    begin
                        if (sts.cnt_zero)
                        begin
                            cmd.res_status = gipq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.res_load = 1'b0;
                            cmd.ptr_zero = 1'b1;
                            state_next   = S_POP0;
                        end
                    end
                    default:
                    begin
                        cmd.res_status = gipq_pkg::ST_DONE;
                    end
                endcase
            end
            S_DIV:
            begin
                if (sts.div_busy)
                begin
                    cmd.div_step = 1'b1;
                end
                else
                begin
                    cmd.tile_rd = 1'b1;
                    cmd.cell_rd = 1'b1;
                    state_next  = S_TILE;
                end
            end
            S_TILE:
            begin
                cmd.t_load = 1'b1;
                state_next = S_WRAP;
            end
            S_WRAP:
            begin
                if (!sts.steps_zero)
                begin
                    cmd.wrap_step = 1'b1;
                end
                else
                begin
                    cmd.cand_load = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!sts.flag_set)
                begin
                    if (sts.cnt_full)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = gipq_pkg::ST_FULL;
                        cmd.res_rc     = 1'b1;
                        cmd.res_dist   = gipq_pkg::RD_CAND;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        cmd.flag_wr     = 1'b1;
                        cmd.flag_val    = 1'b1;
                        cmd.tent_wr     = 1'b1;
                        cmd.ptr_set_cnt = 1'b1;
                        is_dec_next     = 1'b0;
                        state_next      = S_INS_RD;
                    end
                end
                else if (sts.improved)
                begin
                    cmd.tent_wr  = 1'b1;
                    cmd.ptr_zero = 1'b1;
                    is_dec_next  = 1'b1;
                    state_next   = S_FIND_RD;
                end
                else
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = gipq_pkg::ST_NOT_IMPR;
                    cmd.res_rc     = 1'b1;
                    cmd.res_dist   = gipq_pkg::RD_TENT;
                    state_next     = S_OUT;
                end
            end
            S_FIND_RD:
            begin
                if (sts.ptr_at_cnt)
                begin
                    cmd.ptr_set_cnt = 1'b1;
                    state_next      = S_INS_RD;
                end
                else
                begin
                    cmd.q_rd     = 1'b1;
                    cmd.q_rd_sel = gipq_pkg::QR_CUR;
                    state_next   = S_FIND_CMP;
                end
            end
            S_FIND_CMP:
            begin
                if (sts.match)
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = S_FIND_RD;
                end
            end
            S_SH_RD:
            begin
                if (sts.ptr_last)
                begin
                    cmd.cnt_dec = 1'b1;
                    if (sts.mode == gipq_pkg::MODE_POP)
                    begin
                        cmd.flag_wr    = 1'b1;
                        cmd.res_load   = 1'b1;
                        cmd.res_status = gipq_pkg::ST_DONE;
                        cmd.res_rc     = 1'b1;
                        cmd.res_dist   = gipq_pkg::RD_CAND;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        cmd.ptr_set_cntm1 = 1'b1;
                        state_next        = S_INS_RD;
                    end
                end
                else
                begin
                    cmd.q_rd     = 1'b1;
                    cmd.q_rd_sel = gipq_pkg::QR_INC;
                    state_next   = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                cmd.q_wr    = 1'b1;
                cmd.ptr_inc = 1'b1;
                state_next  = S_SH_RD;
            end
            S_INS_RD:
            begin
                if (sts.ptr_zero)
                begin
                    cmd.q_wr       = 1'b1;
                    cmd.q_wr_new   = 1'b1;
                    cmd.cnt_inc    = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ins_status;
                    cmd.res_rc     = 1'b1;
                    cmd.res_dist   = gipq_pkg::RD_CAND;
                    state_next     = S_OUT;
                end
                else
                begin
                    cmd.q_rd     = 1'b1;
                    cmd.q_rd_sel = gipq_pkg::QR_DEC;
                    state_next   = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                cmd.q_wr = 1'b1;
                if (sts.key_ge)
                begin
                    cmd.ptr_dec = 1'b1;
                    state_next  = S_INS_RD;
                end
                else
                begin
                    cmd.q_wr_new   = 1'b1;
                    cmd.cnt_inc    = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ins_status;
                    cmd.res_rc     = 1'b1;
                    cmd.res_dist   = gipq_pkg::RD_CAND;
                    state_next     = S_OUT;
                end
            end
            S_POP0:
            begin
                cmd.q_rd     = 1'b1;
                cmd.q_rd_sel = gipq_pkg::QR_CUR;
                state_next   = S_POP1;
            end
            S_POP1:
            begin
                cmd.pop_latch = 1'b1;
                state_next    = S_SH_RD;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/gipq_dpath.sv
`default_nettype none
module gipq_dpath #(
    parameter int TILE_SIZE   = gipq_pkg::TILE_SIZE_DEF,
    parameter int TILE_REPEAT = gipq_pkg::TILE_REPEAT_DEF,
    parameter int QUEUE_DEPTH = gipq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [47:0]     s_tdata,
    input  wire logic            m_tready,
    output logic                 m_tvalid,
    output logic      [39:0]     m_tdata,
    input  wire gipq_pkg::cmd_t  cmd,
    output gipq_pkg::sts_t       sts
);

    localparam int GRID    = TILE_SIZE * TILE_REPEAT;
    localparam int TDEPTH  = TILE_SIZE * TILE_SIZE;
    localparam int CDEPTH  = GRID * GRID;
    localparam int TILE_AW = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
    localparam int CELL_AW = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int Q_AW    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int CW      = gipq_pkg::COORD_W;
    localparam int DW      = gipq_pkg::DIST_W;

    // item registers
    logic [1:0]                  mode_reg;
    logic [9:0]                  row_in_reg;
    logic [9:0]                  col_in_reg;
    logic [CW-1:0]               row_reg;
    logic [CW-1:0]               col_reg;
    logic [gipq_pkg::COST_W-1:0] base_reg;
    logic [DW-1:0]               dist_reg;
    logic [CW-1:0]               rrem_reg;
    logic [CW-1:0]               crem_reg;
    logic [gipq_pkg::STEP_W-1:0] steps_reg;
    logic [gipq_pkg::COST_W-1:0] t_reg;
    logic [DW-1:0]               cand_reg;
    logic [CNT_W-1:0]            ptr_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [CELL_AW-1:0]          clr_reg;
    logic [2:0]                  res_status_reg;
    logic [CW-1:0]               res_row_reg;
    logic [CW-1:0]               res_col_reg;
    logic [DW-1:0]               res_dist_reg;
    logic                        m_tvalid_reg;
    logic [39:0]                 m_tdata_reg;

    // memory ports
    logic [gipq_pkg::COST_W-1:0] tile_rd_data;
    logic [TILE_AW-1:0]          tile_addr;
    logic [CELL_AW-1:0]          cell_addr;
    logic [CELL_AW-1:0]          flag_wr_addr;
    logic                        flag_rd_data;
    logic [DW-1:0]               tent_rd_data;
    logic [Q_AW-1:0]             q_rd_addr;
    logic [gipq_pkg::ENTRY_W-1:0] q_wr_data;
    logic [gipq_pkg::ENTRY_W-1:0] q_rd_data;
    logic [CW-1:0]               q_rd_row;
    logic [CW-1:0]               q_rd_col;
    logic [DW-1:0]               q_rd_key;
    logic [DW:0]                 sum;
    logic [DW-1:0]               res_dist;
    logic [gipq_pkg::COST_W-1:0] t_wrap;
    logic                        r_ge;
    logic                        c_ge;

    assign tile_addr = TILE_AW'(int'(rrem_reg) * TILE_SIZE + int'(crem_reg));
    assign cell_addr = CELL_AW'(int'(row_reg) * GRID + int'(col_reg));
    assign flag_wr_addr = cmd.flag_clr ? clr_reg : cell_addr;
    assign q_rd_row  = q_rd_data[CW-1:0];
    assign q_rd_col  = q_rd_data[2*CW-1:CW];
    assign q_rd_key  = q_rd_data[gipq_pkg::ENTRY_W-1:2*CW];
    assign q_wr_data = cmd.q_wr_new ? {cand_reg, col_reg, row_reg} : q_rd_data;
    assign r_ge      = int'(rrem_reg) >= TILE_SIZE;
    assign c_ge      = int'(crem_reg) >= TILE_SIZE;
    assign sum       = {1'b0, dist_reg} + (DW + 1)'(t_reg);
    assign t_wrap    = (t_reg >= 4'd9) ? 4'd1 : t_reg + 4'd1;

    // queue read address
    always_comb
    begin
        case (cmd.q_rd_sel)
            gipq_pkg::QR_DEC: q_rd_addr = Q_AW'(ptr_reg - 1'b1);
            gipq_pkg::QR_INC: q_rd_addr = Q_AW'(ptr_reg + 1'b1);
            default:          q_rd_addr = Q_AW'(ptr_reg);
        endcase
    end

    // result distance
    always_comb
    begin
        case (cmd.res_dist)
            gipq_pkg::RD_CAND: res_dist = cand_reg;
            gipq_pkg::RD_TENT: res_dist = tent_rd_data;
            default:           res_dist = '0;
        endcase
    end

    // status to the controller
    always_comb
    begin
        sts.mode       = mode_reg;
        sts.tile_ok    = !row_in_reg[9] && !col_in_reg[9]
                         && (int'(row_in_reg[8:0]) < TILE_SIZE)
                         && (int'(col_in_reg[8:0]) < TILE_SIZE);
        sts.grid_ok    = !row_in_reg[9] && !col_in_reg[9]
                         && (int'(row_in_reg[8:0]) < GRID)
                         && (int'(col_in_reg[8:0]) < GRID);
        sts.cnt_zero   = (cnt_reg == '0);
        sts.cnt_full   = (int'(cnt_reg) >= QUEUE_DEPTH);
        sts.div_busy   = r_ge || c_ge;
        sts.steps_zero = (steps_reg == '0);
        sts.flag_set   = flag_rd_data;
        sts.improved   = cand_reg < tent_rd_data;
        sts.key_ge     = q_rd_key >= cand_reg;
        sts.match      = (q_rd_row == row_reg) && (q_rd_col == col_reg);
        sts.ptr_zero   = (ptr_reg == '0);
        sts.ptr_at_cnt = (ptr_reg == cnt_reg);
        sts.ptr_last   = ({1'b0, ptr_reg} + 1'b1) >= {1'b0, cnt_reg};
        sts.clr_last   = (int'(clr_reg) == CDEPTH - 1);
        sts.out_free   = !m_tvalid_reg || m_tready;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            mode_reg   <= s_tdata[1:0];
            row_in_reg <= s_tdata[11:2];
            col_in_reg <= s_tdata[21:12];
            row_reg    <= s_tdata[10:2];
            col_reg    <= s_tdata[20:12];
            rrem_reg   <= s_tdata[10:2];
            crem_reg   <= s_tdata[20:12];
            base_reg   <= s_tdata[25:22];
            dist_reg   <= s_tdata[41:26];
            steps_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            if (r_ge)
            begin
                rrem_reg <= CW'(int'(rrem_reg) - TILE_SIZE);
            end
            if (c_ge)
            begin
                crem_reg <= CW'(int'(crem_reg) - TILE_SIZE);
            end
            steps_reg <= steps_reg + (gipq_pkg::STEP_W)'(r_ge) + (gipq_pkg::STEP_W)'(c_ge);
        end
        else if (cmd.wrap_step)
        begin
            steps_reg <= steps_reg - 1'b1;
        end
        else if (cmd.pop_latch)
        begin
            row_reg <= q_rd_row;
            col_reg <= q_rd_col;
        end

        if (cmd.t_load)
        begin
            t_reg <= tile_rd_data;
        end
        else if (cmd.wrap_step)
        begin
            t_reg <= t_wrap;
        end

        if (cmd.cand_load)
        begin
            cand_reg <= sum[DW] ? '1 : sum[DW-1:0];
        end
        else if (cmd.pop_latch)
        begin
            cand_reg <= q_rd_key;
        end

        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_row_reg    <= cmd.res_rc ? row_reg : '0;
            res_col_reg    <= cmd.res_rc ? col_reg : '0;
            res_dist_reg   <= res_dist;
        end

        if (cmd.out_load)
        begin
            m_tdata_reg <= {3'b000, res_dist_reg, res_col_reg, res_row_reg, res_status_reg};
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg      <= '0;
            cnt_reg      <= '0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ptr_zero)
            begin
                ptr_reg <= '0;
            end
            else if (cmd.ptr_set_cnt)
            begin
                ptr_reg <= cnt_reg;
            end
            else if (cmd.ptr_set_cntm1)
            begin
                ptr_reg <= cnt_reg - 1'b1;
            end
            else if (cmd.ptr_inc)
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            else if (cmd.ptr_dec)
            begin
                ptr_reg <= ptr_reg - 1'b1;
            end

            if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (cmd.cnt_dec)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end

            if (cmd.flag_clr)
            begin
                clr_reg <= clr_reg + 1'b1;
            end

            if (cmd.out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // base tile digits
    gipq_ram #(
        .WIDTH (gipq_pkg::COST_W),
        .DEPTH (TDEPTH)
    ) u_tile (
        .clk     (clk),
        .wr_en   (cmd.tile_wr),
        .wr_addr (tile_addr),
        .wr_data (base_reg),
        .rd_en   (cmd.tile_rd),
        .rd_addr (tile_addr),
        .rd_data (tile_rd_data)
    );

    // queued flags, swept to zero after reset
    gipq_ram #(
        .WIDTH (1),
        .DEPTH (CDEPTH)
    ) u_flag (
        .clk     (clk),
        .wr_en   (cmd.flag_wr || cmd.flag_clr),
        .wr_addr (flag_wr_addr),
        .wr_data (cmd.flag_val),
        .rd_en   (cmd.cell_rd),
        .rd_addr (cell_addr),
        .rd_data (flag_rd_data)
    );

    // tentative distances
    gipq_ram #(
        .WIDTH (DW),
        .DEPTH (CDEPTH)
    ) u_tent (
        .clk     (clk),
        .wr_en   (cmd.tent_wr),
        .wr_addr (cell_addr),
        .wr_data (cand_reg),
        .rd_en   (cmd.cell_rd),
        .rd_addr (cell_addr),
        .rd_data (tent_rd_data)
    );

    // sorted queue entries: key, column, row
    gipq_ram #(
        .WIDTH (gipq_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .wr_en   (cmd.q_wr),
        .wr_addr (Q_AW'(ptr_reg)),
        .wr_data (q_wr_data),
        .rd_en   (cmd.q_rd),
        .rd_addr (q_rd_addr),
        .rd_data (q_rd_data)
    );

endmodule
`default_nettype wire

FILE: rtl/grid_indexed_priority_queue_core.sv
// Grid-indexed priority queue with decrease-key for shortest-path search.
// Input stream s_*: one item per command (load base tile digit, relax a
// cell, pop the minimum). Output stream m_*: exactly one result item per
// input item, in order.
// Load, out-of-range and empty-pop items pass through decode straight to the
// output register. A relax adds the tile quotient steps and the cost wrap
// steps, then walks the queue: an insert shifts the entries above the new key,
// a decrease searches for the cell, closes the gap and reinserts. A pop shifts
// the whole queue down.
// The queue memory walk sets the rate; items are processed one
// at a time.
// After reset the queued flag memory is cleared one entry a cycle
// (TILE_SIZE*TILE_REPEAT squared entries, 102400 by default); s_tready stays
// low until then. When the receiver stalls, the result waits in the output
// register and the next item can still be accepted and worked on; it holds
// in its last step until the register is free.
`default_nettype none
module grid_indexed_priority_queue_core #(
    parameter int TILE_SIZE   = gipq_pkg::TILE_SIZE_DEF,
    parameter int TILE_REPEAT = gipq_pkg::TILE_REPEAT_DEF,
    parameter int QUEUE_DEPTH = gipq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // mode[1:0], row[11:2], col[21:12],
                                       // base_cost[25:22], distance_in[41:26]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata   // status[2:0], out_row[11:3],
                                       // out_col[20:12], out_distance[36:21]
);

    gipq_pkg::cmd_t cmd;
    gipq_pkg::sts_t sts;

    gipq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gipq_dpath #(
        .TILE_SIZE   (TILE_SIZE),
        .TILE_REPEAT (TILE_REPEAT),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
`default_nettype wire
